[rtl/dtsp_pkg.sv]
package dtsp_pkg;

  // Record kinds of the result channel
  typedef enum logic [2:0] {
    KIND_CONTENT   = 3'd0,
    KIND_SCHEDULE  = 3'd1,
    KIND_DESC_HDR  = 3'd2,
    KIND_DESC_DATA = 3'd3,
    KIND_TRUNC     = 3'd4
  } kind_e;

  // Number of id bytes ahead of the content count
  localparam logic [2:0] IdBytes = 3'd6;
  // Last byte index of an 8-byte header or schedule group
  localparam logic [2:0] GroupLast = 3'd7;
  // Mask that keeps whole 8-byte schedule groups
  localparam logic [11:0] SchedGroupMask = 12'hFF8;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       section_end;
  } in_t;

  typedef struct packed {
    kind_e       record_kind;
    logic [3:0]  group_id;
    logic [11:0] target_version;
    logic [11:0] new_version;
    logic [1:0]  download_level;
    logic [1:0]  version_indicator;
    logic [3:0]  timeshift_info;
    logic [39:0] start_time;
    logic [23:0] duration;
    logic [7:0]  tag_or_byte;
    logic [7:0]  descriptor_length;
    logic        descriptor_fits;
  } out_t;

endpackage

[rtl/dtsp_in_if.sv]
interface dtsp_in_if;
  logic          valid;
  logic          ready;
  dtsp_pkg::in_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[rtl/dtsp_out_if.sv]
interface dtsp_out_if;
  logic           valid;
  logic           ready;
  dtsp_pkg::out_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[rtl/download_table_section_parser_unit.sv]
// Byte-serial parser for the content loop of a download table section. One payload
// byte is taken per request, every cycle if the result side keeps up; a byte that
// produces a record presents it on rsp_o in the cycle after it is taken, from a
// single output register. The parser state machine and the record fields are
// updated with each accepted byte, so the rate is one byte per clock; req_i.ready
// drops only while a finished record waits in the output register and rsp_o.ready
// is low. A byte flagged section_end returns the parser to its start state.
module download_table_section_parser_unit (
  input logic         clk_i,
  input logic         rst_ni,
  dtsp_in_if.sink     req_i,
  dtsp_out_if.source  rsp_o
);

  typedef enum logic [2:0] {
    PH_IDS    = 3'd0,
    PH_HEADER = 3'd1,
    PH_SCHED  = 3'd2,
    PH_TAG    = 3'd3,
    PH_LEN    = 3'd4,
    PH_DATA   = 3'd5,
    PH_DONE   = 3'd6
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] contents;
    logic [2:0] pos;
  } advance_t;

  phase_e         phase_q, phase_d;
  logic [2:0]     pos_q, pos_d;
  logic [7:0]     contents_q, contents_d;
  logic [63:0]    gather_q, gather_d;
  logic [11:0]    crl_q, crl_d;
  logic [11:0]    srl_q, srl_d;
  logic [12:0]    rc_q, rc_d;
  logic [7:0]     dbl_q, dbl_d;
  logic           kept_q, kept_d;
  logic           out_valid_q;
  dtsp_pkg::out_t out_q;
  dtsp_pkg::out_t rec;
  logic           emit;
  logic           accept;
  logic [7:0]     b;
  logic [63:0]    shifted;
  logic           fits;
  advance_t       adv;

  // Close a content: count down and go to the next header or finish
  function automatic advance_t content_done(logic [7:0] contents);
    advance_t r;
    r.contents = contents - 8'd1;
    r.pos      = 3'd0;
    r.phase    = (r.contents != 8'd0) ? PH_HEADER : PH_DONE;
    return r;
  endfunction

  // Another descriptor if two bytes of the content region remain
  function automatic advance_t after_desc(logic [12:0] rc, logic [11:0] crl,
                                          logic [7:0] contents, logic [2:0] pos);
    advance_t r;
    if ({1'b0, rc} + 14'd2 <= {2'b0, crl}) begin
      r.phase    = PH_TAG;
      r.contents = contents;
      r.pos      = pos;
    end else begin
      r = content_done(contents);
    end
    return r;
  endfunction

  // Stay in the schedule region until it is consumed
  function automatic advance_t region_next(logic [12:0] rc, logic [11:0] srl,
                                           logic [11:0] crl, logic [7:0] contents,
                                           logic [2:0] pos);
    advance_t r;
    if (rc < {1'b0, srl}) begin
      r.phase    = PH_SCHED;
      r.contents = contents;
      r.pos      = pos;
    end else begin
      r = after_desc(rc, crl, contents, pos);
    end
    return r;
  endfunction

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign b           = req_i.payload.payload_byte;
  assign shifted     = {gather_q[55:0], b};
  assign fits        = ({1'b0, rc_q} + 14'd1 + {6'b0, b}) <= {2'b0, crl_q};

  // Parse one byte
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    contents_d = contents_q;
    gather_d   = gather_q;
    crl_d      = crl_q;
    srl_d      = srl_q;
    rc_d       = rc_q;
    dbl_d      = dbl_q;
    kept_d     = kept_q;
    rec        = '0;
    emit       = 1'b0;
    adv        = '{phase: phase_q, contents: contents_q, pos: pos_q};
    case (phase_q)
      PH_IDS: begin
        if (pos_q >= dtsp_pkg::IdBytes) begin
          contents_d = b;
          pos_d      = 3'd0;
          phase_d    = (b != 8'd0) ? PH_HEADER : PH_DONE;
        end else begin
          pos_d = pos_q + 3'd1;
        end
      end
      PH_HEADER: begin
        gather_d = shifted;
        if (pos_q == dtsp_pkg::GroupLast) begin
          rec.record_kind       = dtsp_pkg::KIND_CONTENT;
          rec.group_id          = shifted[63:60];
          rec.target_version    = shifted[59:48];
          rec.new_version       = {shifted[47:40], shifted[39:36]};
          rec.download_level    = shifted[35:34];
          rec.version_indicator = shifted[33:32];
          rec.timeshift_info    = shifted[3:0];
          emit                  = 1'b1;
          crl_d                 = {shifted[31:24], shifted[23:20]};
          srl_d                 = {shifted[15:8], shifted[7:4]};
          rc_d                  = '0;
          adv        = region_next(13'd0, srl_d, crl_d, contents_q, 3'd0);
          phase_d    = adv.phase;
          contents_d = adv.contents;
          pos_d      = adv.pos;
        end else begin
          pos_d = pos_q + 3'd1;
        end
      end
      PH_SCHED: begin
        pos_d = pos_q;
        if (rc_q < {1'b0, srl_q & dtsp_pkg::SchedGroupMask}) begin
          gather_d = shifted;
          if (pos_q == dtsp_pkg::GroupLast) begin
            rec.record_kind = dtsp_pkg::KIND_SCHEDULE;
            rec.start_time  = shifted[63:24];
            rec.duration    = shifted[23:0];
            emit            = 1'b1;
          end
          pos_d = pos_q + 3'd1;
        end
        rc_d       = rc_q + 13'd1;
        adv        = region_next(rc_d, srl_q, crl_q, contents_q, pos_d);
        phase_d    = adv.phase;
        contents_d = adv.contents;
        pos_d      = adv.pos;
      end
      PH_TAG: begin
        gather_d = {56'd0, b};
        rc_d     = rc_q + 13'd1;
        phase_d  = PH_LEN;
      end
      PH_LEN: begin
        rec.record_kind       = dtsp_pkg::KIND_DESC_HDR;
        rec.tag_or_byte       = gather_q[7:0];
        rec.descriptor_length = b;
        rec.descriptor_fits   = fits;
        emit                  = 1'b1;
        rc_d                  = rc_q + 13'd1;
        dbl_d                 = b;
        kept_d                = fits;
        if (b != 8'd0) begin
          phase_d = PH_DATA;
        end else begin
          adv        = after_desc(rc_d, crl_q, contents_q, pos_q);
          phase_d    = adv.phase;
          contents_d = adv.contents;
          pos_d      = adv.pos;
        end
      end
      PH_DATA: begin
        if (kept_q) begin
          rec.record_kind     = dtsp_pkg::KIND_DESC_DATA;
          rec.tag_or_byte     = b;
          rec.descriptor_fits = 1'b1;
          emit                = 1'b1;
        end
        rc_d  = rc_q + 13'd1;
        dbl_d = dbl_q - 8'd1;
        if (dbl_d == 8'd0) begin
          adv        = after_desc(rc_d, crl_q, contents_q, pos_q);
          phase_d    = adv.phase;
          contents_d = adv.contents;
          pos_d      = adv.pos;
        end
      end
      default: begin
      end
    endcase

    // Drop back to the start state at the end of the section
    if (req_i.payload.section_end) begin
      if (phase_d != PH_DONE) begin
        rec             = '0;
        rec.record_kind = dtsp_pkg::KIND_TRUNC;
        emit            = 1'b1;
      end
      phase_d    = PH_IDS;
      pos_d      = '0;
      contents_d = '0;
      gather_d   = '0;
      crl_d      = '0;
      srl_d      = '0;
      rc_d       = '0;
      dbl_d      = '0;
      kept_d     = 1'b0;
    end
  end

  // Hold parser state; advance on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDS;
      pos_q      <= '0;
      contents_q <= '0;
      gather_q   <= '0;
      crl_q      <= '0;
      srl_q      <= '0;
      rc_q       <= '0;
      dbl_q      <= '0;
      kept_q     <= 1'b0;
    end else if (accept) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      contents_q <= contents_d;
      gather_q   <= gather_d;
      crl_q      <= crl_d;
      srl_q      <= srl_d;
      rc_q       <= rc_d;
      dbl_q      <= dbl_d;
      kept_q     <= kept_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= emit;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_q <= rec;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule

[rtl/dtsp_checker.sv]
module dtsp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input dtsp_pkg::out_t out_payload_i
);

  // A new record only follows an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("record appeared without an accepted request");

  // The input side never stalls while the output register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request stalled with empty output register");

  // Data byte records are always kept and carry no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_payload_i.record_kind == dtsp_pkg::KIND_DESC_DATA)
      |-> (out_payload_i.descriptor_fits && out_payload_i.descriptor_length == 8'd0))
    else $error("malformed descriptor data record");

  // A stalled record holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_payload_i)))
    else $error("stalled record changed");

endmodule

bind download_table_section_parser_unit dtsp_checker u_dtsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .out_payload_i (rsp_o.payload)
);

[dv/download_table_section_parser_unit_test.sv]
`timescale 1ns / 100ps

module download_table_section_parser_unit_test;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 20;
  localparam int BytesPerPhase = 160;

  typedef enum logic [2:0] {
    PARSE_IDS,
    PARSE_HEADER,
    PARSE_SCHEDULE,
    PARSE_TAG,
    PARSE_LENGTH,
    PARSE_DATA,
    PARSE_DONE
  } parse_phase_e;

  // Predicts the records of the parser and checks the ones it returns
  class record_tracker;
    dtsp_pkg::out_t expected_q[$];
    int             failures;
    parse_phase_e   phase;
    bit [2:0]       pos;
    bit [7:0]       contents_left;
    bit [63:0]      gather;
    bit [11:0]      content_len;
    bit [11:0]      sched_len;
    bit [12:0]      consumed;
    bit [7:0]       data_left;
    bit             kept;

    function new();
      failures = 0;
      reset_parser();
    endfunction

    function void reset_parser();
      phase = PARSE_IDS;
      pos = '0;
      contents_left = '0;
      gather = '0;
      content_len = '0;
      sched_len = '0;
      consumed = '0;
      data_left = '0;
      kept = 1'b0;
    endfunction

    function void end_content();
      contents_left = contents_left - 8'd1;
      pos = '0;
      phase = (contents_left != 0) ? PARSE_HEADER : PARSE_DONE;
    endfunction

    // Loop on descriptors while two bytes of the content region remain
    function void after_descriptor();
      if (32'(consumed) + 32'd2 <= 32'(content_len)) phase = PARSE_TAG;
      else end_content();
    endfunction

    function void next_region();
      if (32'(consumed) < 32'(sched_len)) phase = PARSE_SCHEDULE;
      else after_descriptor();
    endfunction

    function void note_byte(dtsp_pkg::in_t req);
      dtsp_pkg::out_t rec;
      bit             emit;
      bit [7:0]       b;
      bit             fits;
      rec = '0;
      emit = 1'b0;
      b = req.payload_byte;
      case (phase)
        PARSE_IDS: begin
          if (pos >= dtsp_pkg::IdBytes) begin
            contents_left = b;
            pos = '0;
            phase = (b != 0) ? PARSE_HEADER : PARSE_DONE;
          end else begin
            pos = pos + 3'd1;
          end
        end
        PARSE_HEADER: begin
          gather = {gather[55:0], b};
          if (pos == dtsp_pkg::GroupLast) begin
            rec.record_kind = dtsp_pkg::KIND_CONTENT;
            rec.group_id = gather[63:60];
            rec.target_version = gather[59:48];
            rec.new_version = gather[47:36];
            rec.download_level = gather[35:34];
            rec.version_indicator = gather[33:32];
            rec.timeshift_info = gather[3:0];
            emit = 1'b1;
            content_len = gather[31:20];
            sched_len = gather[15:4];
            consumed = '0;
            pos = '0;
            next_region();
          end else begin
            pos = pos + 3'd1;
          end
        end
        PARSE_SCHEDULE: begin
          // Skip bytes past the last whole group
          if (32'(consumed) < 32'(sched_len & dtsp_pkg::SchedGroupMask)) begin
            gather = {gather[55:0], b};
            if (pos == dtsp_pkg::GroupLast) begin
              rec.record_kind = dtsp_pkg::KIND_SCHEDULE;
              rec.start_time = gather[63:24];
              rec.duration = gather[23:0];
              emit = 1'b1;
            end
            pos = pos + 3'd1;
          end
          consumed = consumed + 13'd1;
          next_region();
        end
        PARSE_TAG: begin
          gather = {56'd0, b};
          consumed = consumed + 13'd1;
          phase = PARSE_LENGTH;
        end
        PARSE_LENGTH: begin
          fits = (32'(consumed) + 32'd1 + 32'(b) <= 32'(content_len));
          rec.record_kind = dtsp_pkg::KIND_DESC_HDR;
          rec.tag_or_byte = gather[7:0];
          rec.descriptor_length = b;
          rec.descriptor_fits = fits;
          emit = 1'b1;
          consumed = consumed + 13'd1;
          data_left = b;
          kept = fits;
          if (b != 0) phase = PARSE_DATA;
          else after_descriptor();
        end
        PARSE_DATA: begin
          if (kept) begin
            rec.record_kind = dtsp_pkg::KIND_DESC_DATA;
            rec.tag_or_byte = b;
            rec.descriptor_fits = 1'b1;
            emit = 1'b1;
          end
          consumed = consumed + 13'd1;
          data_left = data_left - 8'd1;
          if (data_left == 0) after_descriptor();
        end
        default: ;
      endcase
      // An early end replaces any record with a truncated one
      if (req.section_end) begin
        if (phase != PARSE_DONE) begin
          rec = '0;
          rec.record_kind = dtsp_pkg::KIND_TRUNC;
          emit = 1'b1;
        end
        reset_parser();
      end
      if (emit) expected_q.push_back(rec);
    endfunction

    function void compare_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_record(dtsp_pkg::out_t act);
      dtsp_pkg::out_t exp;
      if (expected_q.size() == 0) begin
        $error("record_kind: expected no record, got 0x%0h", act.record_kind);
        failures++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("record_kind", 64'(exp.record_kind), 64'(act.record_kind));
      compare_field("group_id", 64'(exp.group_id), 64'(act.group_id));
      compare_field("target_version", 64'(exp.target_version), 64'(act.target_version));
      compare_field("new_version", 64'(exp.new_version), 64'(act.new_version));
      compare_field("download_level", 64'(exp.download_level), 64'(act.download_level));
      compare_field("version_indicator", 64'(exp.version_indicator),
                    64'(act.version_indicator));
      compare_field("timeshift_info", 64'(exp.timeshift_info), 64'(act.timeshift_info));
      compare_field("start_time", 64'(exp.start_time), 64'(act.start_time));
      compare_field("duration", 64'(exp.duration), 64'(act.duration));
      compare_field("tag_or_byte", 64'(exp.tag_or_byte), 64'(act.tag_or_byte));
      compare_field("descriptor_length", 64'(exp.descriptor_length),
                    64'(act.descriptor_length));
      compare_field("descriptor_fits", 64'(exp.descriptor_fits), 64'(act.descriptor_fits));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  dtsp_in_if  req_if ();
  dtsp_out_if rsp_if ();

  download_table_section_parser_unit DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  record_tracker tracker = new();
  bit [7:0]    section_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off = 1'b0;
  int          bytes_sent = 0;
  int          cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles for the run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Stall the result side at random, or hold it off entirely
  always @(posedge clk) begin
    rsp_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Check returned records, then note accepted requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) tracker.check_record(rsp_if.payload);
      if (req_if.valid && req_if.ready) tracker.note_byte(req_if.payload);
    end
  end

  task automatic hold_results(input int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  task automatic send_byte(input bit [7:0] data, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= '{payload_byte: data, section_end: last};
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the first len bytes of the section, flagging the last one
  task automatic send_section(input int len);
    for (int i = 0; i < len; i++) send_byte(section_q[i], i == len - 1);
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_send[4];
    int unsigned phase_recv[4];
    int          phase_end;
    int          pick;
    int          n_contents;
    int          sched_len;
    int          region;
    int          n_desc;
    int          dlen;
    bit [7:0]    desc_q[$];

    phase_send = '{0, 79, 0, 20};
    phase_recv = '{0, 0, 79, 20};
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero contents, section ends on the count byte
    section_q.delete();
    repeat (6) section_q.push_back(8'hFF);
    section_q.push_back(8'h00);
    send_section(section_q.size());

    // Section ends among the id bytes
    section_q = '{8'h00, 8'h5A};
    send_section(2);

    // One content with every header bit set, then an end inside the schedule
    section_q.delete();
    repeat (6) section_q.push_back(8'h00);
    section_q.push_back(8'h01);
    repeat (8) section_q.push_back(8'hFF);
    section_q.push_back(8'hA5);
    send_section(section_q.size());
    wait_drain();

    phase_end = bytes_sent;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_send[ph];
      recv_stall_pct <= phase_recv[ph];
      phase_end += BytesPerPhase;
      // Back up the result side while requests keep coming
      if (ph == 0) begin
        fork
          hold_results(120);
        join_none
      end
      while (bytes_sent < phase_end) begin
        pick = $urandom_range(99);
        section_q.delete();
        if (pick < 15) begin
          // Noise: random bytes of random length
          repeat ($urandom_range(1, 30)) section_q.push_back(8'($urandom));
          send_section(section_q.size());
        end else begin
          repeat (6) section_q.push_back(8'($urandom));
          n_contents = $urandom_range(3);
          section_q.push_back(8'(n_contents));
          for (int c = 0; c < n_contents; c++) begin
            if ($urandom_range(2) == 0) sched_len = 8 * $urandom_range(2);
            else sched_len = $urandom_range(20);
            desc_q.delete();
            n_desc = $urandom_range(3);
            for (int d = 0; d < n_desc; d++) begin
              dlen = $urandom_range(6);
              desc_q.push_back(8'($urandom));
              desc_q.push_back(8'(dlen));
              repeat (dlen) desc_q.push_back(8'($urandom));
            end
            region = sched_len + desc_q.size();
            // Skew the region now and then so descriptors overrun it
            if ($urandom_range(4) == 0) region = region + $urandom_range(8) - 4;
            if (region < 0) region = 0;
            repeat (4) section_q.push_back(8'($urandom));
            section_q.push_back(region[11:4]);
            section_q.push_back({region[3:0], 4'($urandom)});
            section_q.push_back(sched_len[11:4]);
            section_q.push_back({sched_len[3:0], 4'($urandom)});
            repeat (sched_len) section_q.push_back(8'($urandom));
            foreach (desc_q[k]) section_q.push_back(desc_q[k]);
          end
          repeat ($urandom_range(3)) section_q.push_back(8'($urandom));
          if (pick < 30) send_section($urandom_range(1, section_q.size()));
          else send_section(section_q.size());
        end
      end
      wait_drain();
    end

    repeat (DrainCycles) @(posedge clk);
    if (tracker.failures == 0 && tracker.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
